### rtl/wmtl_pkg.sv
`default_nettype none

package wmtl_pkg;

  // Tiling and table geometry
  localparam int unsigned TILE_PIXELS = 256;
  localparam int unsigned LUT_ENTRIES = 1024;
  localparam int unsigned MAX_ZOOM    = 24;

  // Register stages between an accepted input beat and its output beat
  localparam int unsigned PIPE_DEPTH = 7;

  // Beat widths
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned ZOOM_W     = 5;

  // Table index covers 0..LUT_ENTRIES inclusive
  localparam int unsigned IDX_W = $clog2(LUT_ENTRIES + 1);

  localparam logic [63:0] QONE   = 64'd1 << 30;
  localparam logic [31:0] HALF32 = 32'h8000_0000;
  localparam logic [31:0] FULL32 = 32'hFFFF_FFFF;

  typedef logic [31:0] rom_t [0:LUT_ENTRIES];

  // Fields that ride alongside the y datapath
  typedef struct packed {
    logic [31:0]       xfrac;
    logic [ZOOM_W-1:0] zoom;
    logic              south;
  } side_t;

  // Shift-and-subtract unsigned division, used only while building the table
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    int          i;
    rem = '0;
    quo = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Elaboration-time build of g(a) = asinh(tan a)/(2*pi), Q0.32, a = 0..90 deg.
  // Fixed-point Q2.30 outside the Q60 pi series, truncating at every step.
  function automatic rom_t build_mercator_rom();
    rom_t        rom;
    logic [63:0] pi60, pi30, ln2;
    logic [63:0] p, sum, x, x2, k;
    logic [63:0] th, st, s, ct, c, v, y, e, u, u2, at, n;
    logic        sat;
    int unsigned j, m;
    pi60 = 64'd0;
    // Machin: pi = 16 atan(1/5) - 4 atan(1/239), in Q60
    for (m = 0; m < 2; m++) begin
      x   = (m == 0) ? 64'd5 : 64'd239;
      p   = udiv64(64'd1 << 60, x);
      sum = p;
      x2  = x * x;
      k   = 64'd1;
      while (p != 64'd0) begin
        p = udiv64(p, x2);
        if (k[0]) begin
          sum = sum - udiv64(p, 64'd2 * k + 64'd1);
        end else begin
          sum = sum + udiv64(p, 64'd2 * k + 64'd1);
        end
        k = k + 64'd1;
      end
      if (m == 0) begin
        pi60 = 64'd16 * sum;
      end else begin
        pi60 = pi60 - 64'd4 * sum;
      end
    end
    pi30 = pi60 >> 30;

    // ln2 = 2 atanh(1/3)
    u   = udiv64(QONE, 64'd3);
    u2  = (u * u) >> 30;
    p   = u;
    at  = u;
    for (n = 64'd1; n <= 64'd20; n++) begin
      p  = (p * u2) >> 30;
      at = at + udiv64(p, 64'd2 * n + 64'd1);
    end
    ln2 = 64'd2 * at;

    for (j = 0; j <= LUT_ENTRIES; j++) begin
      th  = udiv64(64'(j) * pi30, 64'd2 * 64'(LUT_ENTRIES));
      st  = th;
      s   = th;
      ct  = QONE;
      c   = QONE;
      sat = 1'b0;
      y   = 64'd0;
      for (n = 64'd1; n <= 64'd12; n++) begin
        st = (st * th) >> 30;
        st = udiv64((st * th) >> 30, (64'd2 * n) * (64'd2 * n + 64'd1));
        ct = (ct * th) >> 30;
        ct = udiv64((ct * th) >> 30, (64'd2 * n - 64'd1) * (64'd2 * n));
        if (n[0]) begin
          s = s - st;
          c = c - ct;
        end else begin
          s = s + st;
          c = c + ct;
        end
      end
      if (c == 64'd0 || c > 64'd2 * QONE || s > 64'd2 * QONE) begin
        sat = 1'b1;
      end else begin
        v = udiv64((QONE + s) << 30, c);
        if (v > QONE) begin
          e = 64'd0;
          while (v >= 64'd2 * QONE) begin
            v = v >> 1;
            e = e + 64'd1;
          end
          u  = udiv64((v - QONE) << 30, v + QONE);
          u2 = (u * u) >> 30;
          p  = u;
          at = u;
          for (n = 64'd1; n <= 64'd20; n++) begin
            p  = (p * u2) >> 30;
            at = at + udiv64(p, 64'd2 * n + 64'd1);
          end
          y = e * ln2 + 64'd2 * at;
        end
        if (y >= pi30) begin
          sat = 1'b1;
        end
      end
      rom[j] = sat ? HALF32 : 32'(udiv64(y << 31, pi30));
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

### rtl/web_mercator_tile_locator.sv
// Channel   Dir  Beat fields (tdata, lowest bit first)
// s_axis    in   latitude[31:0], longitude[63:32], zoom_level[68:64], zero pad to 72
// m_axis    out  tile_column[23:0], tile_row[47:24], pixel_column[55:48],
//                pixel_row[63:56]
//
// Seven register stages, one beat per cycle while the output is not back-pressured.
// Stages: magnitude and table index, table read (two registered ROM ports),
// slope, interpolation multiply, add and clamp, y fraction, tile and pixel.
// Each stage holds its own valid bit; a stage loads when it is empty or its
// successor loads, so bubbles close up under output back-pressure.
// Reset clears the valid bits only; the table is a constant ROM, no fill time.
`default_nettype none

module web_mercator_tile_locator
  import wmtl_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // latitude[31:0], longitude[63:32], zoom_level[68:64], pad[71:69]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // tile_column[23:0], tile_row[47:24], pixel_column[55:48], pixel_row[63:56]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o
);

  localparam rom_t MERC_ROM = build_mercator_rom();
  localparam int unsigned POS_W = 30 + IDX_W;

  // Stage valids and load enables
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic en1, en2, en3, en4, en5, en6, en7;

  assign en7 = !v7_q || m_axis_tready_i;
  assign en6 = !v6_q || en7;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign s_axis_tready_o = en1;
  assign m_axis_tvalid_o = v7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
      if (en7) v7_q <= v6_q;
    end
  end

  // Stage 1: fold latitude to magnitude, clamp, scale to table position; clamp zoom, offset longitude
  logic [31:0]       lat_in, lon_in;
  logic [ZOOM_W-1:0] zoom_in, zoom_cl;
  logic [32:0]       mag_full;
  logic [30:0]       mag;
  logic [POS_W-1:0]  pos;
  side_t             side1_d, side1_q;
  logic [IDX_W-1:0]  idx1_q;
  logic [29:0]       fr1_q;

  assign lat_in  = s_axis_tdata_i[31:0];
  assign lon_in  = s_axis_tdata_i[63:32];
  assign zoom_in = s_axis_tdata_i[68:64];

  always_comb begin
    mag_full = lat_in[31] ? (33'h1_0000_0000 - {1'b0, lat_in}) : {1'b0, lat_in};
    mag      = (mag_full > 33'(QONE)) ? 31'(QONE) : mag_full[30:0];
    pos      = POS_W'(mag) * POS_W'(LUT_ENTRIES);
    zoom_cl  = (zoom_in > ZOOM_W'(MAX_ZOOM)) ? ZOOM_W'(MAX_ZOOM) : zoom_in;
    side1_d.xfrac = lon_in + HALF32;
    side1_d.zoom  = zoom_cl;
    side1_d.south = lat_in[31];
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      side1_q <= side1_d;
      idx1_q  <= pos[POS_W-1:30];
      fr1_q   <= pos[29:0];
    end
  end

  // Stage 2: two registered table reads, neighbour clamped at the last entry
  logic [IDX_W-1:0] idx1_nx;
  logic [31:0]      e0_2_q, e1_2_q;
  logic [29:0]      fr2_q;
  side_t            side2_q;

  assign idx1_nx = (idx1_q == IDX_W'(LUT_ENTRIES)) ? idx1_q : idx1_q + IDX_W'(1);

  always_ff @(posedge clk_i) begin
    if (en2) begin
      e0_2_q  <= MERC_ROM[idx1_q];
      e1_2_q  <= MERC_ROM[idx1_nx];
      fr2_q   <= fr1_q;
      side2_q <= side1_q;
    end
  end

  // Stage 3: slope magnitude and direction
  logic [31:0] e0_3_q, diff3_q;
  logic        up3_q;
  logic [29:0] fr3_q;
  side_t       side3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      up3_q   <= e1_2_q >= e0_2_q;
      diff3_q <= (e1_2_q >= e0_2_q) ? (e1_2_q - e0_2_q) : (e0_2_q - e1_2_q);
      e0_3_q  <= e0_2_q;
      fr3_q   <= fr2_q;
      side3_q <= side2_q;
    end
  end

  // Stage 4: interpolation multiply, 32x30
  logic [61:0] mul3;
  logic [31:0] prod4_q, e0_4_q;
  logic        up4_q;
  side_t       side4_q;

  assign mul3 = 62'(diff3_q) * 62'(fr3_q);

  always_ff @(posedge clk_i) begin
    if (en4) begin
      prod4_q <= mul3[61:30];
      e0_4_q  <= e0_3_q;
      up4_q   <= up3_q;
      side4_q <= side3_q;
    end
  end

  // Stage 5: apply the step, clamp g to one half
  logic [32:0] gsum;
  logic [31:0] g5_q;
  side_t       side5_q;

  assign gsum = up4_q ? ({1'b0, e0_4_q} + {1'b0, prod4_q})
                      : ({1'b0, e0_4_q} - {1'b0, prod4_q});

  always_ff @(posedge clk_i) begin
    if (en5) begin
      g5_q    <= (gsum > {1'b0, HALF32}) ? HALF32 : gsum[31:0];
      side5_q <= side4_q;
    end
  end

  // Stage 6: y fraction, south side saturates at all ones
  logic [32:0] ysouth;
  logic [31:0] yfrac6_q;
  side_t       side6_q;

  assign ysouth = {1'b0, HALF32} + {1'b0, g5_q};

  always_ff @(posedge clk_i) begin
    if (en6) begin
      if (side5_q.south) begin
        yfrac6_q <= (ysouth > {1'b0, FULL32}) ? FULL32 : ysouth[31:0];
      end else begin
        yfrac6_q <= HALF32 - g5_q;
      end
      side6_q <= side5_q;
    end
  end

  // Stage 7: split fractions into tile index and pixel offset
  logic [63:0] xw, yw, xpix, ypix;

  always_comb begin
    xw   = {32'b0, side6_q.xfrac} << side6_q.zoom;
    yw   = {32'b0, yfrac6_q} << side6_q.zoom;
    xpix = {32'b0, xw[31:0]} * 64'(TILE_PIXELS);
    ypix = {32'b0, yw[31:0]} * 64'(TILE_PIXELS);
  end

  always_ff @(posedge clk_i) begin
    if (en7) begin
      m_axis_tdata_o <= {ypix[39:32], xpix[39:32], yw[55:32], xw[55:32]};
    end
  end

endmodule

`default_nettype wire

### rtl/wmtl_port_checker.sv
`default_nettype none

module wmtl_port_checker
  import wmtl_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid_i,
  input wire logic                  s_axis_tready_o,
  // latitude[31:0], longitude[63:32], zoom_level[68:64], pad[71:69]
  input wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input wire logic                  m_axis_tvalid_o,
  input wire logic                  m_axis_tready_i,
  // tile_column[23:0], tile_row[47:24], pixel_column[55:48], pixel_row[63:56]
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  logic       in_beat, out_beat;
  logic [3:0] occ_q, occ_d;

  assign in_beat  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_beat = m_axis_tvalid_o && m_axis_tready_i;

  // Beats in flight
  always_comb begin
    occ_d = occ_q;
    if (in_beat && !out_beat) occ_d = occ_q + 4'd1;
    if (!in_beat && out_beat) occ_d = occ_q - 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 4'd0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // Never more beats in flight than pipeline stages
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= 4'(PIPE_DEPTH))
    else $error("more beats in flight than stages");

  // No output beat without an input beat behind it
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == 4'd0 |-> !m_axis_tvalid_o)
    else $error("output beat with nothing in flight");

  // Input side only stalls when the output is held up
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without output back-pressure");

  // A held output beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("held output beat changed");

endmodule

bind web_mercator_tile_locator wmtl_port_checker u_port_checker (.*);

`default_nettype wire
